FILE: rtl/bcrf_pkg.sv
// bcrf_pkg: shared constants and command/status types for the border region fill.
// No dependencies.
package bcrf_pkg;
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;
    localparam int ROW_W        = 32;
    localparam int RNUM_W       = 5;
    localparam int CFG_W        = 6;

    typedef struct packed {
        logic clear;   // start a new grid
        logic store;   // write accepted row
        logic seed;    // seed marks from border
        logic sweep;   // one growth pass over a row
        logic emit;    // load output register from row index
    } t_cmd;

    typedef struct packed {
        logic last_idx;  // sweep/emit index at final stored row
        logic grew;      // a growth happened during this pass
        logic empty;     // no rows stored
    } t_status;
endpackage

FILE: rtl/bcrf_datapath.sv
// bcrf_datapath: row store, mark store, one-row-per-cycle growth unit, output register.
// Depends on bcrf_pkg.
module bcrf_datapath #(
    parameter int MAX_ROWS = bcrf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = bcrf_pkg::MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bcrf_pkg::t_cmd             i_cmd,
    input  logic [bcrf_pkg::CFG_W-1:0] i_cols,
    input  logic [bcrf_pkg::ROW_W-1:0] i_row_bits,
    input  logic                       i_out_take,
    output bcrf_pkg::t_status          o_status,
    output logic [bcrf_pkg::ROW_W-1:0] o_filled_row_bits,
    output logic [bcrf_pkg::RNUM_W-1:0] o_row_number,
    output logic                       o_last_out,
    output logic                       o_rows_dropped
);
    localparam int DEPTH = (MAX_ROWS > 32) ? 32 : MAX_ROWS;
    localparam int CLIM  = (MAX_COLS > 32) ? 32 : MAX_COLS;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RW    = bcrf_pkg::ROW_W;

    logic [RW-1:0] r_grid  [DEPTH];
    logic [RW-1:0] r_marks [DEPTH];
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [IW-1:0] r_idx;
    logic          r_grew;
    logic [RW-1:0] r_fill_mask;

    logic [5:0]    w_now;
    logic [RW-1:0] w_mask;
    logic [RW-1:0] w_edge;
    logic [IW-1:0] w_last;
    logic [RW-1:0] w_open, w_cur, w_near, w_next, w_up, w_dn, w_seed;

    always_comb begin
        w_now = (i_cols > 6'(CLIM)) ? 6'(CLIM) : i_cols;
        w_mask = (w_now >= 6'd32) ? '1 : ((RW'(1) << w_now[4:0]) - RW'(1));
        w_edge = (w_now == 6'd0) ? '0 : (RW'(1) | (RW'(1) << 5'(w_now - 6'd1)));
        w_last = IW'(r_count - CW'(1));
        w_open = r_grid[r_idx] & r_fill_mask;
        w_cur  = r_marks[r_idx];
        w_up   = (r_idx != '0) ? r_marks[IW'(r_idx - IW'(1))] : '0;
        w_dn   = (r_idx != w_last) ? r_marks[IW'(r_idx + IW'(1))] : '0;
        w_near = (w_cur << 1) | (w_cur >> 1) | w_up | w_dn;
        w_next = w_cur | (w_near & w_open);
        w_seed = ((r_idx == '0) || (r_idx == w_last)) ? r_fill_mask : (w_edge & r_fill_mask);
    end

    assign o_status.last_idx = (r_idx == w_last);
    assign o_status.grew     = r_grew | (i_cmd.sweep && (w_next != w_cur));
    assign o_status.empty    = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_count < CW'(DEPTH))) begin
            r_grid[IW'(r_count)] <= i_row_bits & w_mask;
        end
        if (i_cmd.seed) begin
            r_marks[r_idx] <= w_open & w_seed;
        end else if (i_cmd.sweep) begin
            r_marks[r_idx] <= w_next;
        end
        if (i_cmd.store) begin
            r_fill_mask <= w_mask;
        end
        if (i_cmd.emit) begin
            o_filled_row_bits <= w_cur;
            o_row_number      <= bcrf_pkg::RNUM_W'(r_idx);
            o_last_out        <= (r_idx == w_last);
            o_rows_dropped    <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_grew  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_idx   <= '0;
            end else if (i_cmd.store) begin
                if (r_count < CW'(DEPTH)) r_count <= r_count + CW'(1);
                else                      r_ovf   <= 1'b1;
            end
            if (i_cmd.seed || i_cmd.sweep || (i_cmd.emit && i_out_take)) begin
                r_idx <= (r_idx == w_last) ? '0 : IW'(r_idx + IW'(1));
            end
            if (i_cmd.sweep) begin
                r_grew <= (r_idx == w_last) ? 1'b0 : o_status.grew;
            end
        end
    end
endmodule

FILE: rtl/bcrf_ctrl.sv
// bcrf_ctrl: sequencer for load, seed, growth passes and row output.
// Depends on bcrf_pkg.
module bcrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_row,
    input  logic              i_out_stall,
    input  bcrf_pkg::t_status i_status,
    output bcrf_pkg::t_cmd    o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output logic              o_out_take
);
    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SEED  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_EMIT  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   r_clr, n_clr;
    logic   w_acc;

    // clear cycle also holds the input off
    assign o_in_stall  = (r_state != S_LOAD) || r_clr;
    assign o_out_valid = r_ovalid;
    assign w_acc       = i_in_valid && !o_in_stall;
    // output register frees when empty or being taken
    assign o_out_take  = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && i_out_stall;
        n_clr = 1'b0;
        o_cmd = '0;
        o_cmd.store = w_acc;
        o_cmd.clear = r_clr;
        case (r_state)
            S_LOAD: begin
                if (w_acc && i_last_row) n_state = S_SEED;
            end
            S_SEED: begin
                if (i_status.empty) begin
                    n_state = S_LOAD;
                    n_clr = 1'b1;
                end else begin
                    o_cmd.seed = 1'b1;
                    if (i_status.last_idx) n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.last_idx && !i_status.grew) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_out_take) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid = 1'b1;
                    if (i_status.last_idx) n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!n_ovalid) begin
                    n_state = S_LOAD;
                    n_clr = 1'b1;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ovalid <= 1'b0;
            r_clr    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_clr    <= n_clr;
        end
    end
endmodule

FILE: rtl/border_connected_region_fill.sv
// border_connected_region_fill: top level, config register, controller and datapath.
// Depends on bcrf_pkg, bcrf_ctrl, bcrf_datapath.
//
//  channel | valid       | stall       | payload
//  in      | i_in_valid  | o_in_stall  | i_row_bits, i_last_row
//  out     | o_out_valid | i_out_stall | o_filled_row_bits, o_row_number, o_last_out,
//          |             |             | o_rows_dropped
//  cfg     | i_cfg_we    | -           | i_cfg_data (columns_in_use)
//
// Sequence: a row that is not last is stored when it is accepted. A last row of an
// n-row grid starts n seed steps, then growth passes over the n rows (one row per cycle
// through the single growth unit) until a pass adds nothing, then n output
// steps, a wait for the final row to leave, then a clear during
// which input is stalled.
// Reset: synchronous, active low; clears control, count, width returns to 32.
// Stalls: output stall holds the output register and pauses emission only.
module border_connected_region_fill #(
    parameter int MAX_ROWS = bcrf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = bcrf_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bcrf_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bcrf_pkg::ROW_W-1:0]  i_row_bits,
    input  logic                        i_last_row,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bcrf_pkg::ROW_W-1:0]  o_filled_row_bits,
    output logic [bcrf_pkg::RNUM_W-1:0] o_row_number,
    output logic                        o_last_out,
    output logic                        o_rows_dropped
);
    logic [bcrf_pkg::CFG_W-1:0] r_cols;
    bcrf_pkg::t_cmd    w_cmd;
    bcrf_pkg::t_status w_status;
    logic              w_take;

    // columns_in_use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= bcrf_pkg::CFG_W'(32);
        end else if (i_cfg_we) begin
            r_cols <= i_cfg_data;
        end
    end

    bcrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_row  (i_last_row),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_take  (w_take)
    );

    bcrf_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cols            (r_cols),
        .i_row_bits        (i_row_bits),
        .i_out_take        (w_take),
        .o_status          (w_status),
        .o_filled_row_bits (o_filled_row_bits),
        .o_row_number      (o_row_number),
        .o_last_out        (o_last_out),
        .o_rows_dropped    (o_rows_dropped)
    );

    // input is never taken while a growth pass (sweep) runs
    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep |-> o_in_stall) else $error("input open during sweep");
    // a held result keeps its row number
    a_hold_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_row_number))
        else $error("row number moved under stall");
    // seed and sweep never issued together
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.seed && w_cmd.sweep)) else $error("seed and sweep overlap");
endmodule
